>>> sv/pdfe_pkg.sv
// types and constants shared by the pulse-distance frame encoder
package pdfe_pkg;

    // widths of the fields and registers
    localparam int BIT_TIME_W = 15;
    localparam int DUR_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int SEG_IDX_W  = 6;

    // register indexes on the configuration port
    typedef logic [CFG_ADDR_W-1:0] reg_index_t;
    localparam reg_index_t REG_BIT_TIME    = 2'd0;
    localparam reg_index_t REG_HEADER_HIGH = 2'd1;
    localparam reg_index_t REG_HEADER_LOW  = 2'd2;

    // register reset values
    localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST    = 15'd500;
    localparam logic [DUR_W-1:0]      HEADER_HIGH_RST = 16'd10000;
    localparam logic [DUR_W-1:0]      HEADER_LOW_RST  = 16'd5000;

    // segment numbering inside one frame
    typedef logic [SEG_IDX_W-1:0] seg_idx_t;
    localparam seg_idx_t SEG_LEAD_HI    = 6'd0;
    localparam seg_idx_t SEG_LEAD_LO    = 6'd1;
    localparam seg_idx_t SEG_HDR_HI     = 6'd2;
    localparam seg_idx_t SEG_HDR_LO     = 6'd3;
    localparam seg_idx_t SEG_DATA_FIRST = 6'd4;
    localparam seg_idx_t SEG_DATA_LAST  = 6'd35;
    localparam seg_idx_t SEG_STOP_HI    = 6'd36;
    localparam seg_idx_t SEG_STOP_LO    = 6'd37;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_DATA  = 1'b1
    } action_t;

    // input request
    typedef struct packed {
        action_t             action;
        logic [BYTE_W-1:0]   value;
    } in_item_t;

    // one line segment
    typedef struct packed {
        logic                level;
        logic [DUR_W-1:0]    duration_us;
        logic                last;
        logic                frame_end;
    } out_item_t;

    // classified work for the segment sequencer
    typedef struct packed {
        logic                is_start;
        logic [BYTE_W-1:0]   data;
        logic                with_stop;
    } cmd_t;

    // timing registers as seen by the sequencer
    typedef struct packed {
        logic [BIT_TIME_W-1:0] bit_time_us;
        logic [DUR_W-1:0]      header_high_us;
        logic [DUR_W-1:0]      header_low_us;
    } cfg_t;

endpackage

>>> sv/pdfe_fifo.sv
// small register queue used between the encoder stages
module pdfe_fifo #(
    parameter int  DEPTH  = 2,
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output item_t rdata,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    // handshake qualification
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // fill count stays within the depth and agrees with the pointer distance
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

>>> sv/pdfe_front.sv
// front end: frame tracking and request classification
module pdfe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  pdfe_pkg::in_item_t item,
    output logic              cmd_push,
    output pdfe_pkg::cmd_t    cmd
);

    import pdfe_pkg::*;

    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic              frame_open_reg, frame_open_next;
    logic [BYTE_W-1:0] bytes_dec;

    assign bytes_dec = bytes_left_reg - BYTE_W'(1);

    // classify the request and update frame state
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        frame_open_next = frame_open_reg;
        cmd_push        = 1'b0;
        cmd.is_start    = (item.action == ACT_START);
        cmd.data        = item.value;
        cmd.with_stop   = 1'b0;
        if (accept)
        begin
            case (item.action)
                ACT_START:
                begin
                    cmd_push        = 1'b1;
                    cmd.with_stop   = (item.value == '0);
                    bytes_left_next = item.value;
                    frame_open_next = (item.value != '0);
                end
                ACT_DATA:
                begin
                    // data outside an open frame is dropped
                    if (frame_open_reg)
                    begin
                        cmd_push        = 1'b1;
                        cmd.with_stop   = (bytes_dec == '0);
                        bytes_left_next = bytes_dec;
                        frame_open_next = (bytes_dec != '0);
                    end
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            frame_open_reg <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            frame_open_reg <= frame_open_next;
        end
    end

    // an open frame always has bytes outstanding
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg == (bytes_left_reg != '0))
        else $error("frame open flag and byte count disagree");

    // the closing byte of a frame requests a stop pulse
    a_close_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && !cmd.is_start && !frame_open_next) |-> cmd.with_stop)
        else $error("frame closed without stop pulse");

endmodule

>>> sv/pdfe_back.sv
// back end: segment sequencer, one line segment per cycle while the segment queue is not full
module pdfe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pdfe_pkg::cfg_t     cfg,
    input  logic               cmd_empty,
    input  pdfe_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    input  logic               seg_full,
    output logic               seg_push,
    output pdfe_pkg::out_item_t seg
);

    import pdfe_pkg::*;

    logic              busy_reg, busy_next;
    seg_idx_t          idx_reg, idx_next;
    cmd_t              cmd_reg, cmd_next;
    logic              emit, final_seg, load;
    logic [DUR_W-1:0]  t_one, t_two, hdr_hi, hdr_lo;
    seg_idx_t          rel;
    logic [2:0]        bit_sel;
    logic              bit_val;

    // zero timing registers count as one
    assign t_one  = (cfg.bit_time_us == '0) ? DUR_W'(1) : DUR_W'(cfg.bit_time_us);
    assign t_two  = {t_one[DUR_W-2:0], 1'b0};
    assign hdr_hi = (cfg.header_high_us == '0) ? DUR_W'(1) : cfg.header_high_us;
    assign hdr_lo = (cfg.header_low_us == '0) ? DUR_W'(1) : cfg.header_low_us;

    // sequencing control
    assign emit      = busy_reg && !seg_full;
    assign final_seg = (idx_reg == SEG_STOP_LO)
                       || ((idx_reg == SEG_DATA_LAST) && !cmd_reg.with_stop);
    assign load      = !cmd_empty && (!busy_reg || (emit && final_seg));
    assign cmd_pop   = load;
    assign seg_push  = emit;

    // bit selection inside the byte and complement
    assign rel     = idx_reg - SEG_DATA_FIRST;
    assign bit_sel = rel[3:1];
    assign bit_val = cmd_reg.data[bit_sel] ^ rel[4];

    // segment contents
    always_comb
    begin
        seg.last      = final_seg;
        seg.frame_end = 1'b0;
        seg.level     = 1'b1;
        seg.duration_us = t_one;
        case (idx_reg) inside
            SEG_LEAD_HI:
            begin
                seg.level = 1'b1;
            end
            SEG_LEAD_LO:
            begin
                seg.level = 1'b0;
            end
            SEG_HDR_HI:
            begin
                seg.level       = 1'b1;
                seg.duration_us = hdr_hi;
            end
            SEG_HDR_LO:
            begin
                seg.level       = 1'b0;
                seg.duration_us = hdr_lo;
            end
            [SEG_DATA_FIRST:SEG_DATA_LAST]:
            begin
                seg.level       = !rel[0];
                seg.duration_us = (rel[0] && bit_val) ? t_two : t_one;
            end
            SEG_STOP_HI:
            begin
                seg.level = 1'b1;
            end
            SEG_STOP_LO:
            begin
                seg.level     = 1'b0;
                seg.frame_end = 1'b1;
            end
            default:
            begin
                seg.level = 1'b0;
            end
        endcase
    end

    // sequencer state update
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        cmd_next  = cmd_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cmd_next  = cmd;
            idx_next  = cmd.is_start ? SEG_LEAD_HI : SEG_DATA_FIRST;
        end
        else if (emit && final_seg)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + SEG_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= SEG_LEAD_HI;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // segment index stays inside the frame layout
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= SEG_STOP_LO))
        else $error("segment index past stop pulse");

    // preamble segments only come from a start request
    a_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (idx_reg < SEG_DATA_FIRST)) |-> cmd_reg.is_start)
        else $error("preamble segment for a data request");

    // a non-final segment advances the index by one
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !final_seg) |=> (busy_reg && (idx_reg == $past(idx_reg) + SEG_IDX_W'(1))))
        else $error("segment index did not advance");

    // stop segments only appear when requested
    a_stop_req: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (idx_reg > SEG_DATA_LAST)) |-> cmd_reg.with_stop)
        else $error("stop pulse without request");

endmodule

>>> sv/pulse_distance_frame_encoder_top.sv
// a request passes the command queue and the sequencer registers to the result queue
// the sequencer makes one segment per cycle while the result queue has room; a data
// byte gives 32 segments, 34 when it closes the frame; a start gives 36, or 38 for a
// zero count; requests queue up to CMD_DEPTH deep and results up to OUT_DEPTH deep
// reset: timing registers to 500, 10000 and 5000 us, queues empty, no frame open
module pulse_distance_frame_encoder_top #(
    parameter int CMD_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_en,
    input  logic [pdfe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [pdfe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 push,
    input  pdfe_pkg::in_item_t                   item,
    output logic                                 full,
    input  logic                                 pop,
    output pdfe_pkg::out_item_t                  result,
    output logic                                 empty
);

    import pdfe_pkg::*;

    logic [BIT_TIME_W-1:0] bit_time_reg, bit_time_next;
    logic [DUR_W-1:0]      header_high_reg, header_high_next;
    logic [DUR_W-1:0]      header_low_reg, header_low_next;
    cfg_t                  cfg;
    logic                  accept;
    logic                  cmd_push, cmd_pop, cmd_empty, cmd_full;
    cmd_t                  cmd_in, cmd_out;
    logic                  seg_push, seg_full;
    out_item_t             seg;

    // configuration register writes
    always_comb
    begin
        bit_time_next    = bit_time_reg;
        header_high_next = header_high_reg;
        header_low_next  = header_low_reg;
        if (cfg_en)
        begin
            case (cfg_addr)
                REG_BIT_TIME:    bit_time_next    = cfg_data[BIT_TIME_W-1:0];
                REG_HEADER_HIGH: header_high_next = cfg_data;
                REG_HEADER_LOW:  header_low_next  = cfg_data;
                default:         bit_time_next    = bit_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_time_reg    <= BIT_TIME_RST;
            header_high_reg <= HEADER_HIGH_RST;
            header_low_reg  <= HEADER_LOW_RST;
        end
        else
        begin
            bit_time_reg    <= bit_time_next;
            header_high_reg <= header_high_next;
            header_low_reg  <= header_low_next;
        end
    end

    assign cfg.bit_time_us    = bit_time_reg;
    assign cfg.header_high_us = header_high_reg;
    assign cfg.header_low_us  = header_low_reg;

    // request side handshake
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    pdfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // classified requests waiting for the sequencer
    pdfe_fifo #(
        .DEPTH  (CMD_DEPTH),
        .item_t (cmd_t)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    pdfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .seg_full  (seg_full),
        .seg_push  (seg_push),
        .seg       (seg)
    );

    // finished segments waiting to be taken
    pdfe_fifo #(
        .DEPTH  (OUT_DEPTH),
        .item_t (out_item_t)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (seg_push),
        .wdata (seg),
        .full  (seg_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule
